[rtl/rgb_to_hsv_converter_top_macros.svh]
// Assertion macros shared by the converter's checker.
`ifndef RGB_TO_HSV_CONVERTER_TOP_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RHC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("rgb_to_hsv_converter assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("rgb_to_hsv_converter assertion failed");

`endif

[rtl/rhc_pkg.sv]
// Shared widths and stage types of the RGB to HSV converter.
`default_nettype none

package rhc_pkg;

  localparam int CHANNEL_BITS = 16;
  localparam int HSV_BITS     = 16;
  // One quotient bit per divider stage.
  localparam int QUOT_BITS    = HSV_BITS;
  // Six times delta needs three bits above a channel.
  localparam int DEN_BITS     = CHANNEL_BITS + 3;
  localparam int SNUM_BITS    = CHANNEL_BITS + QUOT_BITS;

  typedef logic [CHANNEL_BITS-1:0] chan_t;
  typedef logic [HSV_BITS-1:0]     hsv_t;

  // Operands handed from the front end to the divider pipeline.
  typedef struct packed {
    logic [DEN_BITS-1:0]  hnum;
    logic [DEN_BITS-1:0]  hden;
    logic [SNUM_BITS-1:0] snum;
    chan_t                bright;
    logic                 grey;
  } rhc_prep_t;

  // State of both long divisions inside one divider stage.
  typedef struct packed {
    logic [DEN_BITS-1:0] hrem;
    logic [DEN_BITS-1:0] hden;
    logic [QUOT_BITS-1:0] hq;
    chan_t               srem;
    logic [QUOT_BITS-1:0] sq;
    chan_t               bright;
    logic                grey;
  } rhc_div_t;

endpackage

`default_nettype wire

[rtl/rhc_ifs.sv]
// Valid/ready channel interfaces for RGB input words and HSV output words.
`default_nettype none

interface rhc_rgb_if import rhc_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t red;
  chan_t green;
  chan_t blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rhc_hsv_if import rhc_pkg::*; ();
  logic  valid;
  logic  ready;
  hsv_t  hue;
  hsv_t  saturation;
  chan_t brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

`default_nettype wire

[rtl/rgb_to_hsv_converter_top.sv]
// RGB to HSV converter: front end, divider pipeline and output register.
// The data path holds 21 register stages from the input to the output register.
// Throughput: one pixel per cycle while the output is not stalled; the 16-stage divider pipeline sets the depth.
// The whole pipeline advances whenever the output register is empty or being taken.
// Reset (rst_ni low, asynchronous) clears all valid bits; payload registers keep data.
`default_nettype none

module rgb_to_hsv_converter_top import rhc_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rhc_rgb_if.sink    rgb_i,
  rhc_hsv_if.source  hsv_o
);

  logic      adv;
  logic      prep_valid;
  rhc_prep_t prep;
  logic      div_valid;
  rhc_div_t  div_res;

  logic  out_valid_q;
  hsv_t  out_hue_q;
  hsv_t  out_sat_q;
  chan_t out_bright_q;

  assign adv         = !out_valid_q || hsv_o.ready;
  assign rgb_i.ready = adv;

  rhc_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (rgb_i.valid),
    .red_i   (rgb_i.red),
    .green_i (rgb_i.green),
    .blue_i  (rgb_i.blue),
    .valid_o (prep_valid),
    .prep_o  (prep)
  );

  rhc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (prep_valid),
    .prep_i  (prep),
    .valid_o (div_valid),
    .res_o   (div_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= div_valid;
    end
  end

  // A grey or black pixel has no hue and no saturation.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_hue_q    <= div_res.grey ? '0 : div_res.hq;
      out_sat_q    <= div_res.grey ? '0 : div_res.sq;
      out_bright_q <= div_res.bright;
    end
  end

  assign hsv_o.valid      = out_valid_q;
  assign hsv_o.hue        = out_hue_q;
  assign hsv_o.saturation = out_sat_q;
  assign hsv_o.brightness = out_bright_q;

endmodule

`default_nettype wire

[rtl/rhc_prep.sv]
// Front end: max/min, sector, hue numerator and divisor, saturation dividend.
`default_nettype none

module rhc_prep import rhc_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      en_i,
  input  wire logic      valid_i,
  input  wire chan_t     red_i,
  input  wire chan_t     green_i,
  input  wire chan_t     blue_i,
  output logic           valid_o,
  output rhc_prep_t      prep_o
);

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sect_e;

  localparam int NS_BITS = CHANNEL_BITS + 4;

  // Stage A: extremes and sector.
  logic  a_valid_q;
  chan_t a_red_q, a_green_q, a_blue_q, a_hi_q, a_lo_q;
  chan_t a_hi_d, a_lo_d;
  sect_e a_sect_q, a_sect_d;

  // Stage B: delta and the sector's channel difference.
  logic                         b_valid_q;
  chan_t                        b_delta_q, b_hi_q;
  logic signed [CHANNEL_BITS:0] b_diff_q, b_diff_d;
  sect_e                        b_sect_q;

  // Stage C: raw numerator, divisor and saturation dividend.
  logic                        c_valid_q;
  logic signed [NS_BITS-1:0]   c_num_q, c_num_d;
  logic [DEN_BITS-1:0]         c_six_q;
  logic [SNUM_BITS-1:0]        c_snum_q;
  chan_t                       c_hi_q;
  logic                        c_grey_q;
  logic signed [NS_BITS-1:0]   c_offs;
  logic signed [NS_BITS-1:0]   c_wrap;

  // Stage D: wrapped numerator, handed on.
  logic      d_valid_q;
  rhc_prep_t d_prep_q;

  always_comb begin
    a_hi_d = red_i;
    a_lo_d = red_i;
    if (green_i > a_hi_d) a_hi_d = green_i;
    if (blue_i > a_hi_d)  a_hi_d = blue_i;
    if (green_i < a_lo_d) a_lo_d = green_i;
    if (blue_i < a_lo_d)  a_lo_d = blue_i;
    // Ties go to red first, then green.
    if (red_i >= green_i && red_i >= blue_i) begin
      a_sect_d = SECT_RED;
    end else if (green_i >= blue_i) begin
      a_sect_d = SECT_GREEN;
    end else begin
      a_sect_d = SECT_BLUE;
    end
  end

  always_comb begin
    unique case (a_sect_q)
      SECT_RED:   b_diff_d = $signed({1'b0, a_green_q}) - $signed({1'b0, a_blue_q});
      SECT_GREEN: b_diff_d = $signed({1'b0, a_blue_q}) - $signed({1'b0, a_red_q});
      SECT_BLUE:  b_diff_d = $signed({1'b0, a_red_q}) - $signed({1'b0, a_green_q});
      default:    b_diff_d = '0;
    endcase
  end

  always_comb begin
    unique case (b_sect_q)
      SECT_GREEN: c_offs = $signed({3'b000, b_delta_q, 1'b0});
      SECT_BLUE:  c_offs = $signed({2'b00, b_delta_q, 2'b00});
      default:    c_offs = '0;
    endcase
    c_num_d = NS_BITS'(b_diff_q) + c_offs;
  end

  assign c_wrap = c_num_q + $signed({1'b0, c_six_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      d_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_red_q   <= red_i;
      a_green_q <= green_i;
      a_blue_q  <= blue_i;
      a_hi_q    <= a_hi_d;
      a_lo_q    <= a_lo_d;
      a_sect_q  <= a_sect_d;

      b_delta_q <= a_hi_q - a_lo_q;
      b_hi_q    <= a_hi_q;
      b_diff_q  <= b_diff_d;
      b_sect_q  <= a_sect_q;

      c_num_q  <= c_num_d;
      c_six_q  <= {1'b0, b_delta_q, 2'b00} + {2'b00, b_delta_q, 1'b0};
      // delta * 65535 written as delta * 65536 - delta.
      c_snum_q <= {b_delta_q, {QUOT_BITS{1'b0}}} - SNUM_BITS'(b_delta_q);
      c_hi_q   <= b_hi_q;
      c_grey_q <= (b_delta_q == '0);

      d_prep_q.hnum   <= c_num_q[NS_BITS-1] ? c_wrap[DEN_BITS-1:0] : c_num_q[DEN_BITS-1:0];
      d_prep_q.hden   <= c_six_q;
      d_prep_q.snum   <= c_snum_q;
      d_prep_q.bright <= c_hi_q;
      d_prep_q.grey   <= c_grey_q;
    end
  end

  assign valid_o = d_valid_q;
  assign prep_o  = d_prep_q;

endmodule

`default_nettype wire

[rtl/rhc_div.sv]
// Pipelined restoring dividers for hue and saturation, one quotient bit per stage.
`default_nettype none

module rhc_div import rhc_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      en_i,
  input  wire logic      valid_i,
  input  wire rhc_prep_t prep_i,
  output logic           valid_o,
  output rhc_div_t       res_o
);

  // One shift-compare-subtract step of both divisions.
  function automatic rhc_div_t div_step(rhc_div_t s);
    logic [DEN_BITS:0]     ht;
    logic [CHANNEL_BITS:0] st;
    rhc_div_t              r;
    r  = s;
    ht = {s.hrem, 1'b0};
    if (ht >= {1'b0, s.hden}) begin
      r.hrem = DEN_BITS'(ht - {1'b0, s.hden});
      r.hq   = {s.hq[QUOT_BITS-2:0], 1'b1};
    end else begin
      r.hrem = ht[DEN_BITS-1:0];
      r.hq   = {s.hq[QUOT_BITS-2:0], 1'b0};
    end
    // The low dividend bits leave sq at the top as quotient bits enter below.
    st = {s.srem, s.sq[QUOT_BITS-1]};
    if (st >= {1'b0, s.bright}) begin
      r.srem = CHANNEL_BITS'(st - {1'b0, s.bright});
      r.sq   = {s.sq[QUOT_BITS-2:0], 1'b1};
    end else begin
      r.srem = st[CHANNEL_BITS-1:0];
      r.sq   = {s.sq[QUOT_BITS-2:0], 1'b0};
    end
    return r;
  endfunction

  rhc_div_t init;
  rhc_div_t stg_q [QUOT_BITS];
  logic     vld_q [QUOT_BITS];

  // Both numerators start below their divisors, so the remainders seed directly.
  always_comb begin
    init.hrem   = prep_i.hnum;
    init.hden   = prep_i.hden;
    init.hq     = '0;
    init.srem   = prep_i.snum[SNUM_BITS-1:QUOT_BITS];
    init.sq     = prep_i.snum[QUOT_BITS-1:0];
    init.bright = prep_i.bright;
    init.grey   = prep_i.grey;
  end

  for (genvar i = 0; i < QUOT_BITS; i++) begin : g_stage
    rhc_div_t src;
    logic     src_v;

    if (i == 0) begin : g_first
      assign src   = init;
      assign src_v = valid_i;
    end else begin : g_next
      assign src   = stg_q[i-1];
      assign src_v = vld_q[i-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_q[i] <= div_step(src);
      end
    end
  end

  assign valid_o = vld_q[QUOT_BITS-1];
  assign res_o   = stg_q[QUOT_BITS-1];

endmodule

`default_nettype wire

[rtl/rhc_checker.sv]
// Port-level checker for the RGB to HSV converter, bound to the top level.
`default_nettype none

`include "rgb_to_hsv_converter_top_macros.svh"

module rhc_checker import rhc_pkg::*; (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  input wire logic  in_ready_i,
  input wire logic  out_valid_i,
  input wire logic  out_ready_i,
  input wire hsv_t  hue_i,
  input wire hsv_t  sat_i,
  input wire chan_t bright_i
);

  // A held output word stays put until it is taken.
  `RHC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(hue_i) && $stable(sat_i) && $stable(bright_i))

  // The input side stalls only while a finished word waits at the output.
  `RHC_ASSERT_IMPL(a_in_ready, clk_i, rst_ni, 1'b1, in_ready_i == (!out_valid_i || out_ready_i))

  // Zero saturation means a grey pixel, which has zero hue.
  `RHC_ASSERT_IMPL(a_grey_hue, clk_i, rst_ni, out_valid_i && sat_i == '0, hue_i == '0)

  // A black pixel has neither saturation nor hue.
  `RHC_ASSERT_IMPL(a_black, clk_i, rst_ni, out_valid_i && bright_i == '0, sat_i == '0 && hue_i == '0)

endmodule

bind rgb_to_hsv_converter_top rhc_checker u_rhc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (rgb_i.ready),
  .out_valid_i (hsv_o.valid),
  .out_ready_i (hsv_o.ready),
  .hue_i       (hsv_o.hue),
  .sat_i       (hsv_o.saturation),
  .bright_i    (hsv_o.brightness)
);

`default_nettype wire

[dv/tb_rgb_to_hsv_converter_top.sv]
// Self-checking testbench for the RGB to HSV converter, with a predictor and random stalls.
`timescale 1ns / 100ps

module tb_rgb_to_hsv_converter_top;
  import rhc_pkg::*;

  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned PIPE_LATENCY     = 21;
  localparam int unsigned LONG_HOLD_CYCLES = 150;
  localparam int unsigned SEGMENTS         = 12;
  localparam int unsigned SEGMENT_PIXELS   = 50;
  localparam int unsigned PAUSE_SEGMENT    = 4;
  localparam int unsigned HOLD_SEGMENT     = 6;
  localparam int unsigned DIRECTED_COUNT   = 22;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_word_t;

  typedef struct packed {
    hsv_t  hue;
    hsv_t  saturation;
    chan_t brightness;
  } hsv_word_t;

  // Directed pixel; the HSV fields are used only when known is set.
  typedef struct packed {
    rgb_word_t pixel;
    bit        known;
    hsv_word_t hsv;
  } pixel_case_t;

  localparam pixel_case_t DIRECTED [DIRECTED_COUNT] = '{
    // Black, white and grey pixels.
    '{'{16'h0000, 16'h0000, 16'h0000}, 1'b1, '{16'h0000, 16'h0000, 16'h0000}},
    '{'{16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, '{16'h0000, 16'h0000, 16'hFFFF}},
    '{'{16'h8000, 16'h8000, 16'h8000}, 1'b1, '{16'h0000, 16'h0000, 16'h8000}},
    // Pure primaries at full scale and at the smallest code.
    '{'{16'hFFFF, 16'h0000, 16'h0000}, 1'b1, '{16'h0000, 16'hFFFF, 16'hFFFF}},
    '{'{16'h0000, 16'hFFFF, 16'h0000}, 1'b1, '{16'h5555, 16'hFFFF, 16'hFFFF}},
    '{'{16'h0000, 16'h0000, 16'hFFFF}, 1'b1, '{16'hAAAA, 16'hFFFF, 16'hFFFF}},
    '{'{16'h0001, 16'h0000, 16'h0000}, 1'b1, '{16'h0000, 16'hFFFF, 16'h0001}},
    '{'{16'h0000, 16'h0000, 16'h0001}, 1'b1, '{16'hAAAA, 16'hFFFF, 16'h0001}},
    // Red maximum with a negative numerator that wraps.
    '{'{16'hFFFF, 16'h0000, 16'h0001}, 1'b0, '0},
    // Ties between channels, mostly between the largest ones.
    '{'{16'hFFFF, 16'hFFFF, 16'h0000}, 1'b0, '0},
    '{'{16'h0000, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
    '{'{16'hFFFF, 16'h0000, 16'hFFFF}, 1'b0, '0},
    '{'{16'hFFFE, 16'hFFFF, 16'hFFFE}, 1'b0, '0},
    '{'{16'hFFFF, 16'hFFFE, 16'hFFFF}, 1'b0, '0},
    '{'{16'h8000, 16'h7FFF, 16'h8000}, 1'b0, '0},
    '{'{16'h0000, 16'h0001, 16'h0001}, 1'b0, '0},
    // Mixed colors in every sector.
    '{'{16'hAAAA, 16'h5555, 16'h0000}, 1'b0, '0},
    '{'{16'h5555, 16'hAAAA, 16'hFFFF}, 1'b0, '0},
    '{'{16'h1234, 16'h5678, 16'h9ABC}, 1'b0, '0},
    '{'{16'h0003, 16'h0002, 16'h0001}, 1'b0, '0},
    '{'{16'h0001, 16'h0003, 16'h0002}, 1'b0, '0},
    '{'{16'h0002, 16'h0001, 16'h0003}, 1'b0, '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  rhc_rgb_if rgb_if ();
  rhc_hsv_if hsv_if ();

  rgb_to_hsv_converter_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rgb_i  (rgb_if),
    .hsv_o  (hsv_if)
  );

  always #5ns clk_i = ~clk_i;

  hsv_word_t   pending_hsv_q[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          long_hold_req = 1'b0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH at %0t: %s got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Exact fixed-point conversion; hue wraps into the six sectors around the circle.
  function automatic hsv_word_t hsv_of_pixel(input rgb_word_t px);
    hsv_word_t res;
    longint    rv;
    longint    gv;
    longint    bv;
    longint    hi;
    longint    lo;
    longint    delta;
    longint    num;
    rv = px.red;
    gv = px.green;
    bv = px.blue;
    hi = rv;
    lo = rv;
    if (gv > hi) hi = gv;
    if (bv > hi) hi = bv;
    if (gv < lo) lo = gv;
    if (bv < lo) lo = bv;
    delta = hi - lo;
    res = '0;
    if (delta != 0) begin
      if (hi == rv) begin
        num = gv - bv;
      end else if (hi == gv) begin
        num = bv - rv + 2 * delta;
      end else begin
        num = rv - gv + 4 * delta;
      end
      if (num < 0) num += 6 * delta;
      res.hue = hsv_t'((num * 65536) / (6 * delta));
    end
    if (hi != 0) res.saturation = hsv_t'((delta * 65535) / hi);
    res.brightness = chan_t'(hi);
    return res;
  endfunction

  function automatic chan_t near_code(input chan_t base);
    int t;
    t = int'(base) + int'($urandom_range(0, 6)) - 3;
    if (t < 0) t = 0;
    if (t > 65535) t = 65535;
    return chan_t'(t);
  endfunction

  function automatic chan_t extreme_code();
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return '1;
      default: return chan_t'($urandom);
    endcase
  endfunction

  function automatic rgb_word_t random_pixel();
    rgb_word_t   px;
    chan_t       top;
    int unsigned mask;
    case ($urandom_range(0, 7)) inside
      0, 1: px = '{chan_t'($urandom), chan_t'($urandom), chan_t'($urandom)};
      2: begin
        // Chosen channels share the maximum; the rest lie at or below it.
        top  = chan_t'($urandom_range(1, 65535));
        mask = $urandom_range(1, 7);
        px.red   = mask[0] ? top : chan_t'($urandom_range(0, top));
        px.green = mask[1] ? top : chan_t'($urandom_range(0, top));
        px.blue  = mask[2] ? top : chan_t'($urandom_range(0, top));
      end
      3: begin
        top = chan_t'($urandom);
        px  = '{near_code(top), near_code(top), near_code(top)};
      end
      4: px = '{chan_t'($urandom_range(0, 7)), chan_t'($urandom_range(0, 7)),
                chan_t'($urandom_range(0, 7))};
      5: px = '{extreme_code(), extreme_code(), extreme_code()};
      6: px = '{chan_t'(1) << $urandom_range(0, 15), chan_t'(1) << $urandom_range(0, 15),
                chan_t'(1) << $urandom_range(0, 15)};
      default: px = '{chan_t'($urandom_range(16'hFF00, 16'hFFFF)),
                      chan_t'($urandom_range(16'hFF00, 16'hFFFF)),
                      chan_t'($urandom_range(16'hFF00, 16'hFFFF))};
    endcase
    return px;
  endfunction

  task automatic send_pixel(input rgb_word_t px, input hsv_word_t want, input bit idle_on);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      rgb_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rgb_if.valid <= 1'b1;
    rgb_if.red   <= px.red;
    rgb_if.green <= px.green;
    rgb_if.blue  <= px.blue;
    do @(posedge clk_i); while (!(rgb_if.valid && rgb_if.ready));
    pending_hsv_q.push_back(want);
  endtask

  task automatic drain_pending();
    rgb_if.valid <= 1'b0;
    while (pending_hsv_q.size() != 0) @(posedge clk_i);
  endtask

  // Pixel source: directed table, then random segments.
  initial begin : pixel_source
    rgb_word_t px;
    bit        tx_idle_on;
    rst_ni       <= 1'b0;
    rgb_if.valid <= 1'b0;
    rgb_if.red   <= '0;
    rgb_if.green <= '0;
    rgb_if.blue  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      px = DIRECTED[i].pixel;
      send_pixel(px, DIRECTED[i].known ? DIRECTED[i].hsv : hsv_of_pixel(px), 1'b1);
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      // Let the pipeline run dry once before a segment starts.
      if (seg == PAUSE_SEGMENT) drain_pending();
      // Back-to-back words against a stalled sink fill the pipeline.
      if (seg == HOLD_SEGMENT) begin
        tx_idle_on    = 1'b0;
        long_hold_req = 1'b1;
      end
      for (int k = 0; k < SEGMENT_PIXELS; k++) begin
        px = random_pixel();
        send_pixel(px, hsv_of_pixel(px), tx_idle_on);
      end
    end

    drain_pending();
    repeat (2 * PIPE_LATENCY) @(posedge clk_i);
    if (error_count == 0 && pending_hsv_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Result sink with random back-pressure and one long hold-off.
  initial begin : result_sink
    int unsigned stall;
    int unsigned taken;
    bit          rx_idle_on;
    hsv_if.ready <= 1'b0;
    taken      = 0;
    rx_idle_on = 1'b1;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hsv_if.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
      end
      if (taken % 40 == 0) rx_idle_on = ($urandom_range(0, 3) != 0);
      stall = rx_idle_on ? $urandom_range(0, 8) : 0;
      if (stall != 0) begin
        hsv_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      hsv_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(hsv_if.valid && hsv_if.ready));
      taken++;
    end
  end

  always @(posedge clk_i) begin : result_check
    hsv_word_t want;
    if (rst_ni && hsv_if.valid && hsv_if.ready) begin
      if (pending_hsv_q.size() == 0) begin
        report_mismatch("unexpected word, hue", hsv_if.hue, 0);
      end else begin
        want = pending_hsv_q.pop_front();
        if (hsv_if.hue !== want.hue) report_mismatch("hue", hsv_if.hue, want.hue);
        if (hsv_if.saturation !== want.saturation) begin
          report_mismatch("saturation", hsv_if.saturation, want.saturation);
        end
        if (hsv_if.brightness !== want.brightness) begin
          report_mismatch("brightness", hsv_if.brightness, want.brightness);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
